// ===== hw/rtl/stbs_pkg.sv =====
package stbs_pkg;

  localparam int KEY_W   = 64;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 8;
  localparam int OUT_W   = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic append;
    logic init;
    logic probe;
    logic compare;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  range_empty;
    logic  key_eq;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/sorted_table_binary_search.sv =====
// search: load the word, init the range, then a probe and a compare per step until a hit or an empty range;
// at most 9 probes for a full table of 256 entries (each a registered read and a compare)
// clear, append and unused kinds: load the word, execute it, then emit the result
// one word in flight at a time; the next word is taken once the result is registered
// rst clears the entry count and the output valid; table contents are not cleared
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_CHARS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stbs_pkg::KEY_W-1:0]        s_tdata,  // key
  input  logic [stbs_pkg::KIND_W-1:0]       s_tuser,  // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stbs_pkg::OUT_W-1:0]        m_tdata   // found, position, status
);

  stbs_pkg::dp_cmd_t    cmd;
  stbs_pkg::dp_status_t stat;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stbs_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_CHARS   (KEY_CHARS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hw/rtl/stbs_ctrl.sv =====
module stbs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  stbs_pkg::dp_status_t stat,
  output stbs_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.kind)
          stbs_pkg::KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          stbs_pkg::KIND_APPEND: begin
            cmd.append = 1'b1;
            state_next = S_DONE;
          end
          stbs_pkg::KIND_SEARCH: begin
            cmd.init   = 1'b1;
            state_next = S_PROBE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_PROBE: begin
        if (stat.range_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = stat.key_eq ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/stbs_dpath.sv =====
module stbs_dpath #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_CHARS   = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stbs_pkg::dp_cmd_t                 cmd,
  output stbs_pkg::dp_status_t              stat,
  input  logic [stbs_pkg::KEY_W-1:0]        s_tdata,
  input  logic [stbs_pkg::KIND_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stbs_pkg::OUT_W-1:0]        m_tdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [stbs_pkg::KEY_W-1:0] KEY_MASK =
    ~((64'd1 << (stbs_pkg::KEY_W - 8 * KEY_CHARS)) - 64'd1);

  logic [stbs_pkg::KEY_W-1:0] key_table [TABLE_DEPTH];
  logic [stbs_pkg::KEY_W-1:0] rd_data;
  logic [stbs_pkg::KEY_W-1:0] key_r;
  stbs_pkg::kind_t            kind_r;
  logic [CW-1:0]              count;
  logic [CW-1:0]              lo;
  logic [CW-1:0]              hi;
  logic [CW-1:0]              mid;
  logic [CW-1:0]              mid_next;
  logic [CW:0]                mid_sum;
  logic                       hit;
  logic [stbs_pkg::POS_W-1:0] pos;
  logic                       full_err;
  logic                       full;
  logic                       out_free;

  // hi is one past the last live entry, so floor midpoint is (lo + hi - 1) / 2
  assign mid_sum  = {1'b0, lo} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
  assign mid_next = mid_sum[CW:1];
  assign full     = (count == CW'(TABLE_DEPTH));
  assign out_free = !m_tvalid || m_tready;

  assign stat.kind        = kind_r;
  assign stat.range_empty = (lo >= hi);
  assign stat.key_eq      = (rd_data == key_r);
  assign stat.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      key_table[count[IW-1:0]] <= key_r;
    end
    if (cmd.probe) begin
      rd_data <= key_table[mid_next[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && !full) begin
        count <= count + CW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= s_tdata & KEY_MASK;
      kind_r   <= stbs_pkg::kind_t'(s_tuser);
      hit      <= 1'b0;
      pos      <= '0;
      full_err <= 1'b0;
    end
    if (cmd.append && full) begin
      full_err <= 1'b1;
    end
    if (cmd.init) begin
      lo <= '0;
      hi <= count;
    end
    if (cmd.probe) begin
      mid <= mid_next;
    end
    if (cmd.compare) begin
      if (rd_data == key_r) begin
        hit <= 1'b1;
        pos <= stbs_pkg::POS_W'(mid);
      end else if (rd_data < key_r) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.emit) begin
      m_tdata <= {{(stbs_pkg::OUT_W - stbs_pkg::POS_W - 2){1'b0}}, full_err, pos, hit};
    end
  end

endmodule

// ===== verif/sorted_table_binary_search_tb.sv =====
module sorted_table_binary_search_tb;

  localparam int KEY_W = stbs_pkg::KEY_W;
  localparam int KIND_W = stbs_pkg::KIND_W;
  localparam int POS_W = stbs_pkg::POS_W;
  localparam int OUT_W = stbs_pkg::OUT_W;
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_CHARS = 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_WORDS = 900;
  localparam int QUIET_FROM = 780;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 200;

  class lookup_scoreboard;
    typedef struct {
      bit found;
      bit [POS_W-1:0] position;
      bit status;
    } lookup_result_t;

    bit [KEY_W-1:0] key_store [TABLE_DEPTH];
    int unsigned loaded;
    lookup_result_t pending_results[$];
    int mismatches;

    function new();
      loaded = 0;
      mismatches = 0;
    endfunction

    function bit [KEY_W-1:0] char_mask();
      return ~((64'd1 << (KEY_W - 8 * KEY_CHARS)) - 64'd1);
    endfunction

    // floor midpoint over the loaded entries
    function void probe_table(bit [KEY_W-1:0] key, output bit hit,
                              output bit [POS_W-1:0] pos);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = int'(loaded) - 1;
      hit = 1'b0;
      pos = '0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key_store[mid % TABLE_DEPTH] == key) begin
          hit = 1'b1;
          pos = POS_W'(mid);
          return;
        end else if (key_store[mid % TABLE_DEPTH] < key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    endfunction

    function void note_word(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] raw_key);
      lookup_result_t r;
      bit [KEY_W-1:0] key;
      key = raw_key & char_mask();
      r.found = 1'b0;
      r.position = '0;
      r.status = 1'b0;
      case (kind)
        stbs_pkg::KIND_CLEAR: loaded = 0;
        stbs_pkg::KIND_APPEND: begin
          if (loaded < TABLE_DEPTH) begin
            key_store[loaded] = key;
            loaded++;
          end else begin
            r.status = 1'b1;
          end
        end
        stbs_pkg::KIND_SEARCH: probe_table(key, r.found, r.position);
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
      mismatches++;
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    endtask

    task check_word(logic [OUT_W-1:0] word);
      lookup_result_t r;
      if (pending_results.size() == 0) begin
        report("unexpected word", word[POS_W-1:0], '0);
      end else begin
        r = pending_results.pop_front();
        if (word[0] !== r.found) report("found", POS_W'(word[0]), POS_W'(r.found));
        if (word[8:1] !== r.position) report("position", word[8:1], r.position);
        if (word[9] !== r.status) report("status", POS_W'(word[9]), POS_W'(r.status));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [KEY_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  lookup_scoreboard sb = new();
  int words_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS(KEY_CHARS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_table_binary_search_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // receiver side stalls
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    sb.note_word(kind, key);
    words_sent++;
    if (words_sent == HOLD_AT) hold_req = 1'b1;
    if (words_sent >= QUIET_FROM) idle_on = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] text_key(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[63 - 8 * i -: 8] = s[i];
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int n;
    k = '0;
    case ($urandom_range(0, 2))
      0: k = {$urandom, $urandom};
      1: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) k[63 - 8 * i -: 8] = 8'($urandom_range(97, 122));
      end
      default: k = KEY_W'($urandom_range(0, 15)) << (8 * $urandom_range(0, 7));
    endcase
    return k;
  endfunction

  // clear, load keys, then search them, neighbours and random keys
  task automatic run_sequence(input int n_keys, input int n_searches, input bit ordered);
    logic [KEY_W-1:0] keys[$];
    logic [KEY_W-1:0] k;
    send_word(stbs_pkg::KIND_CLEAR, random_key());
    for (int i = 0; i < n_keys; i++) keys.push_back(random_key());
    if (ordered) keys.sort();
    foreach (keys[i]) begin
      if ($urandom_range(0, 19) == 0) send_word(KIND_W'($urandom_range(0, 3)), random_key());
      send_word(stbs_pkg::KIND_APPEND, keys[i]);
    end
    for (int i = 0; i < n_searches; i++) begin
      if (keys.size() > 0 && $urandom_range(0, 2) != 0) begin
        k = keys[$urandom_range(0, keys.size() - 1)];
        case ($urandom_range(0, 3))
          0: k = k + 64'd1;
          1: k = k - 64'd1;
          default: ;
        endcase
      end else begin
        k = random_key();
      end
      if ($urandom_range(0, 24) == 0) send_word(KIND_W'($urandom_range(0, 3)), random_key());
      send_word(stbs_pkg::KIND_SEARCH, k);
    end
  endtask

  initial begin
    int n_keys;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_word(stbs_pkg::KIND_SEARCH, '0);
    send_word(stbs_pkg::KIND_SEARCH, '1);
    send_word(KIND_UNUSED, '1);
    send_word(stbs_pkg::KIND_APPEND, '0);
    send_word(stbs_pkg::KIND_APPEND, text_key("ab"));
    send_word(stbs_pkg::KIND_APPEND, text_key("abc"));
    send_word(stbs_pkg::KIND_APPEND, text_key("zzzzzzzz"));
    send_word(stbs_pkg::KIND_APPEND, '1);
    send_word(stbs_pkg::KIND_SEARCH, '0);
    send_word(stbs_pkg::KIND_SEARCH, '1);
    send_word(stbs_pkg::KIND_SEARCH, text_key("abc"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("abb"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("abd"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("ab"));
    send_word(stbs_pkg::KIND_CLEAR, '1);
    send_word(stbs_pkg::KIND_SEARCH, text_key("abc"));
    send_word(stbs_pkg::KIND_APPEND, text_key("m"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("m"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("a"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("z"));
    send_word(KIND_UNUSED, text_key("m"));
    send_word(stbs_pkg::KIND_SEARCH, text_key("m"));

    // fill past the end so appends are refused
    run_sequence(TABLE_DEPTH + 3, 24, 1'b1);
    while (words_sent < TARGET_WORDS) begin
      if (words_sent < 500 && $urandom_range(0, 11) == 0) n_keys = $urandom_range(200, 256);
      else n_keys = $urandom_range(0, 40);
      run_sequence(n_keys, $urandom_range(4, 30), $urandom_range(0, 7) != 0);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("sorted_table_binary_search_tb: PASS");
    end else begin
      $display("sorted_table_binary_search_tb: FAIL");
    end
    $finish;
  end

endmodule
